FILE: hdl/lcg_window_sum_matcher_top_assert.svh
// ----------------------------------------------------------------------------
// lcg window sum matcher assertion macros
// concurrent checks on clk, disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef LCG_WINDOW_SUM_MATCHER_TOP_ASSERT_SVH
`define LCG_WINDOW_SUM_MATCHER_TOP_ASSERT_SVH

// condition holds at every edge
`define LCGW_ASSERT_NOW(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// consequent holds in the same cycle
`define LCGW_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent holds in the following cycle
`define LCGW_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/lcgw_pkg.sv
// ----------------------------------------------------------------------------
// lcgw_pkg
// types and constants shared by the lcg window sum matcher
// ----------------------------------------------------------------------------
package lcgw_pkg;

	localparam int unsigned SEED_W   = 32;
	localparam int unsigned VALUE_W  = 14;
	localparam int unsigned TARGET_W = 24;
	localparam int unsigned SUM_W    = 25;
	localparam int unsigned COUNT_W  = 32;
	localparam int unsigned CFG_W    = 32;
	localparam int unsigned CFG_IDX_W = 1;
	localparam int unsigned QUOT_W   = 19;
	localparam int unsigned RECIP_SHIFT = 45;

	localparam logic [SEED_W-1:0]   LCG_MUL     = 32'd214013;
	localparam logic [SEED_W-1:0]   LCG_ADD     = 32'd2531011;
	localparam logic [SEED_W-1:0]   SEED_RESET  = 32'd1983;
	localparam logic [VALUE_W-1:0]  VALUE_MOD   = 14'd10000;
	localparam logic [SEED_W-1:0]   VALUE_RECIP = 32'd3518437209;
	localparam logic [TARGET_W-1:0] TARGET_RESET = 24'd1;

	localparam logic [CFG_IDX_W-1:0] REG_TARGET = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_SEED   = 1'b1;

	typedef struct packed {
		logic start_case;
		logic last_signal;
	} item_t;

	typedef struct packed {
		logic [VALUE_W-1:0]  signal_value;
		logic [TARGET_W-1:0] window_sum;
		logic [COUNT_W-1:0]  match_count;
		logic                case_done;
	} result_t;

	typedef struct packed {
		logic [SEED_W-1:0]  next_seed;
		logic [VALUE_W-1:0] value;
	} draw_res_t;

endpackage

FILE: hdl/lcgw_ram.sv
// ----------------------------------------------------------------------------
// lcgw_ram
// generic single write, single read memory with registered read data
// ----------------------------------------------------------------------------
module lcgw_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 2
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic                                       re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: hdl/lcgw_draw.sv
// ----------------------------------------------------------------------------
// lcgw_draw
// one generator step: next seed and value (seed mod 10000) + 1, one stage
// ----------------------------------------------------------------------------
module lcgw_draw (
	input  logic                        clk,
	input  logic [lcgw_pkg::SEED_W-1:0] seed,
	output lcgw_pkg::draw_res_t         res
);

	import lcgw_pkg::*;

	logic [2*SEED_W-1:0]  prod;
	logic [SEED_W-1:0]    seed_s1;
	logic [SEED_W-1:0]    next_s1;
	logic [QUOT_W-1:0]    quot_s1;
	logic [VALUE_W-1:0]   qmul;

	// quotient by reciprocal, exact over the full 32-bit seed range
	assign prod = 64'(seed) * 64'(VALUE_RECIP);

	always_ff @(posedge clk) begin
		seed_s1 <= seed;
		quot_s1 <= prod[RECIP_SHIFT +: QUOT_W];
		next_s1 <= seed * LCG_MUL + LCG_ADD;
	end

	// remainder is below 2^14, so low bits suffice
	assign qmul = quot_s1[VALUE_W-1:0] * VALUE_MOD;
	assign res.value = seed_s1[VALUE_W-1:0] - qmul + 14'd1;
	assign res.next_seed = next_s1;

endmodule

FILE: hdl/lcg_window_sum_matcher_top.sv
// ----------------------------------------------------------------------------
// lcg_window_sum_matcher_top
// counts generated windows whose sum equals a target
// ----------------------------------------------------------------------------
// item channel (item_valid/item_ready/item) carries one tick: start_case
// reseeds both generators and clears sum and count before the tick.
// result channel (result_valid/result_ready/result) returns one result per
// tick: value drawn, trimmed window sum, match count and case_done.
// configuration: cfg_we writes cfg_data to register cfg_index (0 target,
// 1 seed); a new seed is used from the next start_case.
// order: the item transfer starts a registered read of the head seed, then
// ST_MUL, ST_VAL and ST_CHECK follow; each value removed from the window
// repeats them with the tail seed before ST_CHECK loads the result. one item
// is in work at a time; both generators share the one-stage draw unit.
// the seeds live in a two-entry memory with a valid bit per entry; an entry
// not written since reset or start_case reads as the seed then in force.
// reset clears sum, count, valid bits and the result register.
// a stalled result register blocks the next item transfer; the
// finished item waits in the check state until the register frees up.
// ----------------------------------------------------------------------------
`include "lcg_window_sum_matcher_top_assert.svh"

module lcg_window_sum_matcher_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           item_valid,
	output logic                           item_ready,
	input  lcgw_pkg::item_t                item,
	output logic                           result_valid,
	input  logic                           result_ready,
	output lcgw_pkg::result_t              result,
	input  logic                           cfg_we,
	input  logic [lcgw_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [lcgw_pkg::CFG_W-1:0]     cfg_data
);

	import lcgw_pkg::*;

	typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_VAL, ST_CHECK} state_t;
	typedef enum logic [0:0] {GEN_HEAD, GEN_TAIL} gen_t;

	state_t              state_q;
	gen_t                gen_q;
	logic [1:0]          vld_q;
	logic [SEED_W-1:0]   restart_q;
	logic [SEED_W-1:0]   seed_cfg_q;
	logic [TARGET_W-1:0] target_q;
	logic [SUM_W-1:0]    sum_q;
	logic [COUNT_W-1:0]  count_q;
	logic [VALUE_W-1:0]  value_q;
	logic                last_q;
	logic                res_valid_q;
	result_t             res_q;

	logic                ram_we;
	logic                ram_re;
	gen_t                ram_raddr;
	logic [SEED_W-1:0]   ram_rdata;
	logic [SEED_W-1:0]   seed_in;
	draw_res_t           draw_res;
	logic                accept;
	logic                over;
	logic                out_free;
	logic                load_res;
	logic [COUNT_W-1:0]  count_nxt;
	logic [SUM_W-1:0]    value_ext;

	assign item_ready   = (state_q == ST_IDLE);
	assign accept       = item_valid && item_ready;
	assign over         = sum_q > SUM_W'(target_q);
	assign out_free     = !res_valid_q || result_ready;
	assign load_res     = (state_q == ST_CHECK) && !over && out_free;
	assign value_ext    = SUM_W'(draw_res.value);
	assign count_nxt    = (sum_q == SUM_W'(target_q) && count_q != '1) ?
		count_q + COUNT_W'(1) : count_q;

	assign ram_re    = accept || (state_q == ST_CHECK && over);
	assign ram_raddr = (state_q == ST_IDLE) ? GEN_HEAD : GEN_TAIL;
	assign ram_we    = (state_q == ST_VAL);
	assign seed_in   = vld_q[gen_q] ? ram_rdata : restart_q;

	lcgw_ram #(
		.WIDTH (SEED_W),
		.DEPTH (2)
	) u_seed_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (gen_q),
		.wdata (draw_res.next_seed),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	lcgw_draw u_draw (
		.clk  (clk),
		.seed (seed_in),
		.res  (draw_res)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q   <= TARGET_RESET;
			seed_cfg_q <= SEED_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TARGET: target_q   <= cfg_data[TARGET_W-1:0];
				REG_SEED:   seed_cfg_q <= cfg_data;
				default:    ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			gen_q       <= GEN_HEAD;
			vld_q       <= '0;
			restart_q   <= SEED_RESET;
			sum_q       <= '0;
			count_q     <= '0;
			value_q     <= '0;
			last_q      <= 1'b0;
			res_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			if (load_res) begin
				res_valid_q <= 1'b1;
			end else if (result_valid && result_ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						gen_q   <= GEN_HEAD;
						last_q  <= item.last_signal;
						state_q <= ST_MUL;
						if (item.start_case) begin
							vld_q     <= '0;
							restart_q <= seed_cfg_q;
							sum_q     <= '0;
							count_q   <= '0;
						end
					end
				end
				ST_MUL: begin
					state_q <= ST_VAL;
				end
				ST_VAL: begin
					vld_q[gen_q] <= 1'b1;
					if (gen_q == GEN_HEAD) begin
						sum_q   <= sum_q + value_ext;
						value_q <= draw_res.value;
					end else begin
						sum_q <= (value_ext >= sum_q) ? '0 : sum_q - value_ext;
					end
					state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					if (over) begin
						gen_q   <= GEN_TAIL;
						state_q <= ST_MUL;
					end else if (out_free) begin
						count_q            <= count_nxt;
						res_q.signal_value <= value_q;
						res_q.window_sum   <= sum_q[TARGET_W-1:0];
						res_q.match_count  <= count_nxt;
						res_q.case_done    <= last_q;
						state_q            <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

	`LCGW_ASSERT_NXT(a_accept_starts_draw, accept, state_q == ST_MUL, "transfer did not start a draw")
	`LCGW_ASSERT_NOW(a_ram_one_access, !(ram_we && ram_re), "seed memory read and write overlap")
	`LCGW_ASSERT_IMP(a_sum_trimmed, result_valid, result.window_sum <= target_q, "window sum above target")
	`LCGW_ASSERT_IMP(a_value_range, result_valid, result.signal_value >= 14'd1 && result.signal_value <= VALUE_MOD, "value out of range")

endmodule
